FILE: hdl/tnf_pkg.sv
// ----------------------------------------------------------------------------
// tnf_pkg: shared types and constants for the telnet option input filter
// Byte codes, option codes, event kinds and the config/result structs.
// ----------------------------------------------------------------------------
package tnf_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_IAC  = 8'd255;

  // Option codes
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] OPT_MSSP = 8'd70;
  localparam logic [7:0] OPT_COMP = 8'd86;
  localparam logic [7:0] OPT_GMCP = 8'd201;

  // Clamp limit reset values
  localparam logic [15:0] WIDTH_MIN_RST  = 16'd40;
  localparam logic [15:0] WIDTH_MAX_RST  = 16'd250;
  localparam logic [15:0] HEIGHT_MIN_RST = 16'd10;
  localparam logic [15:0] HEIGHT_MAX_RST = 16'd100;

  // Config register indexes
  localparam logic [1:0] REG_WIDTH_MIN  = 2'd0;
  localparam logic [1:0] REG_WIDTH_MAX  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_MIN = 2'd2;
  localparam logic [1:0] REG_HEIGHT_MAX = 2'd3;

  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_DATA       = 4'd1,
    KIND_WONT       = 4'd2,
    KIND_DONT       = 4'd3,
    KIND_MSSP       = 4'd4,
    KIND_COMP_ON    = 4'd5,
    KIND_COMP_OFF   = 4'd6,
    KIND_SIZE_SET   = 4'd7,
    KIND_SIZE_CLR   = 4'd8,
    KIND_GMCP_ON    = 4'd9,
    KIND_GMCP_OFF   = 4'd10
  } kind_t;

  typedef struct packed {
    logic [15:0] width_min;
    logic [15:0] width_max;
    logic [15:0] height_min;
    logic [15:0] height_max;
  } limits_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_val;
    logic [15:0] width;
    logic [15:0] height;
    logic        gmcp;
    logic        compress;
  } result_t;

endpackage

FILE: hdl/tnf_parser.sv
// ----------------------------------------------------------------------------
// tnf_parser: telnet IAC parser and option state
// Holds the parse state, the subnegotiation payload and the option flags,
// and forms the result for the byte presented on step.
// ----------------------------------------------------------------------------
module tnf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  tnf_pkg::limits_t  limits,
  output tnf_pkg::result_t  result
);

  typedef enum logic [5:0] {
    ST_DATA   = 6'b000001,
    ST_IAC    = 6'b000010,
    ST_NEG    = 6'b000100,
    ST_SBOPT  = 6'b001000,
    ST_SBDATA = 6'b010000,
    ST_SBIAC  = 6'b100000
  } state_t;

  state_t      parse_state, parse_state_next;
  logic [7:0]  held_code, held_code_next;
  logic [2:0]  payload_count, payload_count_next;
  logic [7:0]  payload_bytes [4];
  logic [15:0] win_width, win_width_next;
  logic [15:0] win_height, win_height_next;
  logic        gmcp_flag, gmcp_flag_next;
  logic        compress_flag, compress_flag_next;

  logic        pay_we;
  logic [1:0]  pay_idx;
  tnf_pkg::kind_t kind;
  logic [7:0]  eb;

  logic [15:0] naws_w, naws_h, clamp_w, clamp_h;

  assign naws_w = {payload_bytes[0], payload_bytes[1]};
  assign naws_h = {payload_bytes[2], payload_bytes[3]};

  // when the limits cross, values below min get min and all others get max
  assign clamp_w = (naws_w < limits.width_min) ? limits.width_min :
                   (naws_w > limits.width_max) ? limits.width_max : naws_w;
  assign clamp_h = (naws_h < limits.height_min) ? limits.height_min :
                   (naws_h > limits.height_max) ? limits.height_max : naws_h;

  always_comb begin
    parse_state_next   = parse_state;
    held_code_next     = held_code;
    payload_count_next = payload_count;
    win_width_next     = win_width;
    win_height_next    = win_height;
    gmcp_flag_next     = gmcp_flag;
    compress_flag_next = compress_flag;
    pay_we             = 1'b0;
    pay_idx            = payload_count[1:0];
    kind               = tnf_pkg::KIND_NONE;
    eb                 = 8'd0;

    case (parse_state)
      ST_DATA: begin
        if (rx_byte == tnf_pkg::B_IAC) begin
          parse_state_next = ST_IAC;
        end else begin
          kind = tnf_pkg::KIND_DATA;
          eb   = rx_byte;
        end
      end
      ST_IAC: begin
        if (rx_byte == tnf_pkg::B_IAC) begin
          kind = tnf_pkg::KIND_DATA;
          eb   = rx_byte;
          parse_state_next = ST_DATA;
        end else if (rx_byte == tnf_pkg::B_WILL || rx_byte == tnf_pkg::B_WONT ||
                     rx_byte == tnf_pkg::B_DO   || rx_byte == tnf_pkg::B_DONT) begin
          held_code_next   = rx_byte;
          parse_state_next = ST_NEG;
        end else if (rx_byte == tnf_pkg::B_SB) begin
          payload_count_next = 3'd0;
          parse_state_next   = ST_SBOPT;
        end else begin
          parse_state_next = ST_DATA;
        end
      end
      ST_NEG: begin
        if (held_code == tnf_pkg::B_DO || held_code == tnf_pkg::B_DONT) begin
          if (rx_byte == tnf_pkg::OPT_MSSP) begin
            if (held_code == tnf_pkg::B_DO) kind = tnf_pkg::KIND_MSSP;
          end else if (rx_byte == tnf_pkg::OPT_GMCP) begin
            gmcp_flag_next = (held_code == tnf_pkg::B_DO);
            kind = (held_code == tnf_pkg::B_DO) ? tnf_pkg::KIND_GMCP_ON
                                                : tnf_pkg::KIND_GMCP_OFF;
          end else if (rx_byte == tnf_pkg::OPT_COMP) begin
            if (held_code == tnf_pkg::B_DO && !compress_flag) begin
              compress_flag_next = 1'b1;
              kind = tnf_pkg::KIND_COMP_ON;
            end else if (held_code == tnf_pkg::B_DONT && compress_flag) begin
              compress_flag_next = 1'b0;
              kind = tnf_pkg::KIND_COMP_OFF;
            end
          end else if (held_code == tnf_pkg::B_DO) begin
            kind = tnf_pkg::KIND_WONT;
            eb   = rx_byte;
          end
        end else if (held_code == tnf_pkg::B_WILL || held_code == tnf_pkg::B_WONT) begin
          if (rx_byte == tnf_pkg::OPT_NAWS) begin
            if (held_code == tnf_pkg::B_WONT) begin
              win_width_next  = 16'd0;
              win_height_next = 16'd0;
              kind = tnf_pkg::KIND_SIZE_CLR;
            end
          end else if (held_code == tnf_pkg::B_WILL) begin
            kind = tnf_pkg::KIND_DONT;
            eb   = rx_byte;
          end
        end
        parse_state_next = ST_DATA;
      end
      ST_SBOPT: begin
        held_code_next     = rx_byte;
        payload_count_next = 3'd0;
        parse_state_next   = ST_SBDATA;
      end
      ST_SBDATA: begin
        if (rx_byte == tnf_pkg::B_IAC) begin
          parse_state_next = ST_SBIAC;
        end else if (!payload_count[2]) begin
          pay_we = 1'b1;
          payload_count_next = payload_count + 3'd1;
        end
      end
      ST_SBIAC: begin
        if (rx_byte == tnf_pkg::B_IAC) begin
          // escaped 255 inside the payload
          if (!payload_count[2]) begin
            pay_we = 1'b1;
            payload_count_next = payload_count + 3'd1;
          end
          parse_state_next = ST_SBDATA;
        end else begin
          if (rx_byte == tnf_pkg::B_SE) begin
            if (held_code == tnf_pkg::OPT_NAWS) begin
              if (payload_count[2]) begin
                win_width_next  = clamp_w;
                win_height_next = clamp_h;
                kind = tnf_pkg::KIND_SIZE_SET;
              end
            end else if (held_code == tnf_pkg::OPT_MSSP) begin
              kind = tnf_pkg::KIND_MSSP;
            end
          end
          payload_count_next = 3'd0;
          parse_state_next   = ST_DATA;
        end
      end
      default: begin
        parse_state_next = ST_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= ST_DATA;
      held_code     <= 8'd0;
      payload_count <= 3'd0;
      win_width     <= 16'd0;
      win_height    <= 16'd0;
      gmcp_flag     <= 1'b0;
      compress_flag <= 1'b0;
    end else if (step) begin
      parse_state   <= parse_state_next;
      held_code     <= held_code_next;
      payload_count <= payload_count_next;
      win_width     <= win_width_next;
      win_height    <= win_height_next;
      gmcp_flag     <= gmcp_flag_next;
      compress_flag <= compress_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pay_we) begin
      payload_bytes[pay_idx] <= rx_byte;
    end
  end

  assign result.kind     = kind;
  assign result.byte_val = eb;
  assign result.width    = win_width_next;
  assign result.height   = win_height_next;
  assign result.gmcp     = gmcp_flag_next;
  assign result.compress = compress_flag_next;

endmodule

FILE: hdl/telnet_option_input_filter.sv
// ----------------------------------------------------------------------------
// telnet_option_input_filter: telnet receive filter with option negotiation
// Strips IAC sequences, answers option requests, tracks NAWS/GMCP/compress.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per
//   request. Output channel (out_valid/out_ready) returns exactly one result
//   per byte: event_kind, event_byte and the window size and option flags as
//   they stand after that byte.
//   Results are registered: a byte's result shows from the cycle after it is
//   accepted. Throughput is one byte per cycle unless the receiver stalls; the
//   parser and the clamp compares sit between the input port and the single output
//   register, so a new byte is taken in the same cycle that the previous result leaves.
//   When the receiver stalls, the output register holds its result and
//   in_ready drops until out_ready returns; nothing is lost or repeated.
//   Reset (rst, synchronous) puts the parser in the data state, clears the
//   window size and flags, empties the output register and loads the clamp
//   limits with their defaults (40/250 width, 10/100 height).
//   The APB port writes and reads the four 16-bit limits at byte addresses
//   0, 4, 8 and 12; write limits only while the block is idle.
// ----------------------------------------------------------------------------
module telnet_option_input_filter (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_kind,
  output logic [7:0]  event_byte,
  output logic [15:0] window_width,
  output logic [15:0] window_height,
  output logic        gmcp_on,
  output logic        compress_on,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tnf_pkg::limits_t limits;
  tnf_pkg::result_t result;
  tnf_pkg::result_t out_reg;

  logic       in_fire;
  logic       cfg_we;
  logic [1:0] cfg_idx;

  // Configuration registers. Low address bits are ignored.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.width_min  <= tnf_pkg::WIDTH_MIN_RST;
      limits.width_max  <= tnf_pkg::WIDTH_MAX_RST;
      limits.height_min <= tnf_pkg::HEIGHT_MIN_RST;
      limits.height_max <= tnf_pkg::HEIGHT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tnf_pkg::REG_WIDTH_MIN:  limits.width_min  <= pwdata[15:0];
        tnf_pkg::REG_WIDTH_MAX:  limits.width_max  <= pwdata[15:0];
        tnf_pkg::REG_HEIGHT_MIN: limits.height_min <= pwdata[15:0];
        tnf_pkg::REG_HEIGHT_MAX: limits.height_max <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tnf_pkg::REG_WIDTH_MIN:  prdata = {16'd0, limits.width_min};
      tnf_pkg::REG_WIDTH_MAX:  prdata = {16'd0, limits.width_max};
      tnf_pkg::REG_HEIGHT_MIN: prdata = {16'd0, limits.height_min};
      tnf_pkg::REG_HEIGHT_MAX: prdata = {16'd0, limits.height_max};
      default:                 prdata = 32'd0;
    endcase
  end

  // Accept while the output register is empty or draining this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  tnf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (in_fire),
    .rx_byte (rx_byte),
    .limits  (limits),
    .result  (result)
  );

  // Output register: valid under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_reg <= result;
    end
  end

  assign event_kind    = out_reg.kind;
  assign event_byte    = out_reg.byte_val;
  assign window_width  = out_reg.width;
  assign window_height = out_reg.height;
  assign gmcp_on       = out_reg.gmcp;
  assign compress_on   = out_reg.compress;

  // Checks
  a_fire_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted byte produced no result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind <= tnf_pkg::KIND_GMCP_OFF))
    else $error("event kind out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != tnf_pkg::KIND_DATA &&
     event_kind != tnf_pkg::KIND_WONT && event_kind != tnf_pkg::KIND_DONT)
    |-> (event_byte == 8'd0))
    else $error("event byte set for a kind without one");

  a_size_clr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == tnf_pkg::KIND_SIZE_CLR)
    |-> (window_width == 16'd0 && window_height == 16'd0))
    else $error("size cleared but window size nonzero");

  a_comp_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == tnf_pkg::KIND_COMP_ON) |-> compress_on)
    else $error("compress on event without flag");

endmodule

FILE: tb/sv/telnet_option_input_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_input_filter_tb: self-checking bench for the telnet filter
// Streams received bytes through the filter: a short directed table, then
// random telnet traffic (data, escapes, option requests, subnegotiations and
// junk) under six clamp-limit settings. A behavioral copy of the parser
// predicts all but typed rows; results are checked field by field in order.
// ----------------------------------------------------------------------------
module telnet_option_input_filter_tb;

  // Parser states of the behavioral copy
  typedef enum logic [2:0] {
    PS_DATA   = 3'd0,
    PS_IAC    = 3'd1,
    PS_NEG    = 3'd2,
    PS_SBOPT  = 3'd3,
    PS_SBDATA = 3'd4,
    PS_SBIAC  = 3'd5
  } parse_st_t;

  // One row of the directed table; typed rows carry their event in full
  typedef struct {
    logic [7:0]       rx;
    bit               typed;
    tnf_pkg::result_t event_res;
  } dir_row_t;

  localparam int NUM_DIR       = 27;
  localparam int NUM_PHASES    = 6;
  localparam int BYTES_PER_PHASE = 150;
  localparam int SB_KEEP       = 4;
  // No request moved for this many cycles means a hang. The worst legal
  // wait is a receiver stall at 68% idle; the odds that it idles out to this
  // limit are negligible, so this limit only trips on a real hang.
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_PRINTED   = 40;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_kind;
  logic [7:0]  event_byte;
  logic [15:0] window_width;
  logic [15:0] window_height;
  logic        gmcp_on;
  logic        compress_on;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = 4'h0;
  logic [31:0] pwdata    = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  telnet_option_input_filter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .event_byte   (event_byte),
    .window_width (window_width),
    .window_height(window_height),
    .gmcp_on      (gmcp_on),
    .compress_on  (compress_on),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the filter state
  // --------------------------------------------------------------------------
  tnf_pkg::limits_t clamp_lim = '{tnf_pkg::WIDTH_MIN_RST, tnf_pkg::WIDTH_MAX_RST,
                                  tnf_pkg::HEIGHT_MIN_RST, tnf_pkg::HEIGHT_MAX_RST};
  parse_st_t  ps        = PS_DATA;
  logic [7:0] held_cmd  = 8'h00;   // pending verb, or option inside SB
  logic [2:0] sb_count  = 3'd0;
  logic [7:0] sb_keep [SB_KEEP];
  logic [15:0] cur_width  = 16'd0;
  logic [15:0] cur_height = 16'd0;
  logic        cur_gmcp   = 1'b0;
  logic        cur_comp   = 1'b0;

  tnf_pkg::result_t pending_events [$];   // predicted events, oldest first
  int        mismatches   = 0;
  int        bytes_sent   = 0;
  int        stall_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  tnf_pkg::limits_t phase_limits;
  dir_row_t  dir_rows [NUM_DIR];

  function automatic logic [15:0] clamp_size(logic [15:0] v, logic [15:0] lo,
                                             logic [15:0] hi);
    // when the limits are crossed, values below lo get lo and all others get hi
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void keep_sb_byte(logic [7:0] c);
    // first four payload bytes only, count saturates
    if (sb_count < SB_KEEP) begin
      sb_keep[sb_count[1:0]] = c;
      sb_count = sb_count + 3'd1;
    end
  endfunction

  // Advance the copy by one received byte and build the event it produces
  function automatic tnf_pkg::result_t filter_byte(logic [7:0] c);
    tnf_pkg::kind_t   k;
    logic [7:0]       eb;
    logic             want;
    tnf_pkg::result_t r;
    k  = tnf_pkg::KIND_NONE;
    eb = 8'h00;
    case (ps)
      PS_DATA: begin
        if (c == tnf_pkg::B_IAC) ps = PS_IAC;
        else begin
          k  = tnf_pkg::KIND_DATA;
          eb = c;
        end
      end
      PS_IAC: begin
        if (c == tnf_pkg::B_IAC) begin
          k  = tnf_pkg::KIND_DATA;
          eb = c;
          ps = PS_DATA;
        end else if (c == tnf_pkg::B_WILL || c == tnf_pkg::B_WONT ||
                     c == tnf_pkg::B_DO || c == tnf_pkg::B_DONT) begin
          held_cmd = c;
          ps       = PS_NEG;
        end else if (c == tnf_pkg::B_SB) begin
          sb_count = 3'd0;
          ps       = PS_SBOPT;
        end else begin
          ps = PS_DATA;   // standalone command, swallowed
        end
      end
      PS_NEG: begin
        if (held_cmd == tnf_pkg::B_DO || held_cmd == tnf_pkg::B_DONT) begin
          want = (held_cmd == tnf_pkg::B_DO);
          if (c == tnf_pkg::OPT_MSSP) begin
            if (want) k = tnf_pkg::KIND_MSSP;
          end else if (c == tnf_pkg::OPT_GMCP) begin
            cur_gmcp = want;
            k        = want ? tnf_pkg::KIND_GMCP_ON : tnf_pkg::KIND_GMCP_OFF;
          end else if (c == tnf_pkg::OPT_COMP) begin
            // only edges of the flag are reported
            if (want && !cur_comp) begin
              cur_comp = 1'b1;
              k        = tnf_pkg::KIND_COMP_ON;
            end else if (!want && cur_comp) begin
              cur_comp = 1'b0;
              k        = tnf_pkg::KIND_COMP_OFF;
            end
          end else if (want) begin
            k  = tnf_pkg::KIND_WONT;
            eb = c;
          end
        end else begin
          if (c == tnf_pkg::OPT_NAWS) begin
            if (held_cmd == tnf_pkg::B_WONT) begin
              cur_width  = 16'd0;
              cur_height = 16'd0;
              k          = tnf_pkg::KIND_SIZE_CLR;
            end
          end else if (held_cmd == tnf_pkg::B_WILL) begin
            k  = tnf_pkg::KIND_DONT;
            eb = c;
          end
        end
        ps = PS_DATA;
      end
      PS_SBOPT: begin
        held_cmd = c;
        sb_count = 3'd0;
        ps       = PS_SBDATA;
      end
      PS_SBDATA: begin
        if (c == tnf_pkg::B_IAC) ps = PS_SBIAC;
        else keep_sb_byte(c);
      end
      PS_SBIAC: begin
        if (c == tnf_pkg::B_IAC) begin
          keep_sb_byte(c);
          ps = PS_SBDATA;
        end else begin
          if (c == tnf_pkg::B_SE) begin
            if (held_cmd == tnf_pkg::OPT_NAWS) begin
              if (sb_count >= SB_KEEP) begin
                cur_width  = clamp_size({sb_keep[0], sb_keep[1]},
                                        clamp_lim.width_min, clamp_lim.width_max);
                cur_height = clamp_size({sb_keep[2], sb_keep[3]},
                                        clamp_lim.height_min, clamp_lim.height_max);
                k          = tnf_pkg::KIND_SIZE_SET;
              end
            end else if (held_cmd == tnf_pkg::OPT_MSSP) begin
              k = tnf_pkg::KIND_MSSP;
            end
          end
          // anything but IAC or SE after IAC drops the subnegotiation
          sb_count = 3'd0;
          ps       = PS_DATA;
        end
      end
      default: ps = PS_DATA;
    endcase
    r.kind     = k;
    r.byte_val = eb;
    r.width    = cur_width;
    r.height   = cur_height;
    r.gmcp     = cur_gmcp;
    r.compress = cur_comp;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH @%0t %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tnf_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with no request pending", event_kind, -1);
      end else begin
        want = pending_events.pop_front();
        if (event_kind != want.kind)        report_mismatch("event_kind", event_kind, want.kind);
        if (event_byte != want.byte_val)    report_mismatch("event_byte", event_byte, want.byte_val);
        if (window_width != want.width)     report_mismatch("window_width", window_width, want.width);
        if (window_height != want.height)   report_mismatch("window_height", window_height,
                                                            want.height);
        if (gmcp_on != want.gmcp)           report_mismatch("gmcp_on", gmcp_on, want.gmcp);
        if (compress_on != want.compress)   report_mismatch("compress_on", compress_on,
                                                            want.compress);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hang detection: any moved request or config access restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sender
  // --------------------------------------------------------------------------
  // Called at a clock edge. Valid stays high between back-to-back requests;
  // only the payload changes in that step.
  task automatic send_byte(logic [7:0] b, bit typed, tnf_pkg::result_t typed_res);
    tnf_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = filter_byte(b);
    pending_events.push_back(typed ? typed_res : predicted);
    bytes_sent++;
  endtask

  task automatic send_plain(logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_verb();
    case ($urandom_range(3))
      0:       return tnf_pkg::B_WILL;
      1:       return tnf_pkg::B_WONT;
      2:       return tnf_pkg::B_DO;
      default: return tnf_pkg::B_DONT;
    endcase
  endfunction

  // Known options most of the time so every negotiation branch gets hit
  function automatic logic [7:0] pick_option();
    case ($urandom_range(7))
      0:       return tnf_pkg::OPT_NAWS;
      1:       return tnf_pkg::OPT_MSSP;
      2:       return tnf_pkg::OPT_COMP;
      3:       return tnf_pkg::OPT_GMCP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // NAWS bytes lean toward zero so sizes land inside narrow limits too
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(9))
      0, 1:    return tnf_pkg::B_IAC;
      2, 3, 4: return 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random piece of telnet traffic: mostly well-formed, some junk
  task automatic send_random_exchange();
    int         roll;
    int         n;
    logic [7:0] b;
    roll = $urandom_range(99);
    if (roll < 25) begin
      send_plain(8'($urandom_range(254)));
    end else if (roll < 30) begin
      send_plain(tnf_pkg::B_IAC);            // escaped 255
      send_plain(tnf_pkg::B_IAC);
    end else if (roll < 60) begin
      send_plain(tnf_pkg::B_IAC);
      send_plain(pick_verb());
      send_plain(pick_option());
    end else if (roll < 85) begin
      send_plain(tnf_pkg::B_IAC);
      send_plain(tnf_pkg::B_SB);
      roll = $urandom_range(9);
      send_plain(roll < 5 ? tnf_pkg::OPT_NAWS :
                 roll < 7 ? tnf_pkg::OPT_MSSP : 8'($urandom_range(255)));
      // mostly a full NAWS payload, sometimes short or long
      n = ($urandom_range(3) == 0) ? $urandom_range(7) : SB_KEEP;
      repeat (n) begin
        b = pick_payload();
        send_plain(b);
        if (b == tnf_pkg::B_IAC) send_plain(tnf_pkg::B_IAC);
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        send_plain(tnf_pkg::B_IAC);
        send_plain(tnf_pkg::B_SE);
      end else if (roll < 95) begin
        // malformed terminator
        do b = 8'($urandom_range(255)); while (b == tnf_pkg::B_IAC || b == tnf_pkg::B_SE);
        send_plain(tnf_pkg::B_IAC);
        send_plain(b);
      end
      // else left open; following traffic lands in the payload
    end else if (roll < 93) begin
      send_plain(tnf_pkg::B_IAC);            // standalone command
      send_plain(($urandom_range(1) == 0) ? 8'($urandom_range(240, 249))
                                          : 8'($urandom_range(239)));
    end else begin
      send_plain(8'($urandom_range(255)));
    end
  endtask

  // Stop sending and let every pending event come out; extra idle edges
  // then keep config writes clear of the last byte.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Config port
  // --------------------------------------------------------------------------
  task automatic apb_access(logic [1:0] idx, bit wr, logic [15:0] wval,
                            output logic [15:0] rval);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, wval};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);                 // access edge: write lands, read data valid
    rval    = prdata[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [15:0] v);
    logic [15:0] rb;
    apb_access(idx, 1'b1, v, rb);
    case (idx)
      tnf_pkg::REG_WIDTH_MIN:  clamp_lim.width_min  = v;
      tnf_pkg::REG_WIDTH_MAX:  clamp_lim.width_max  = v;
      tnf_pkg::REG_HEIGHT_MIN: clamp_lim.height_min = v;
      default:                 clamp_lim.height_max = v;
    endcase
    apb_access(idx, 1'b0, 16'h0000, rb);
    if (rb != v) report_mismatch("limit readback", rb, v);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 21; recv_idle_pct = 68; end
      1: begin send_idle_pct = 68; recv_idle_pct = 21; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Directed table, run with the reset limits (width 40..250, height 10..100).
  // Typed rows: plain data, escaped 255 and a swallowed command, with
  // everything else still at its reset value.
  // --------------------------------------------------------------------------
  initial begin
    dir_rows = '{
      '{8'h00, 1'b1, '{tnf_pkg::KIND_DATA, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{8'h80, 1'b1, '{tnf_pkg::KIND_DATA, 8'h80, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{tnf_pkg::B_IAC, 1'b1, '{tnf_pkg::KIND_NONE, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{tnf_pkg::B_IAC, 1'b1, '{tnf_pkg::KIND_DATA, 8'hFF, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{tnf_pkg::B_IAC, 1'b1, '{tnf_pkg::KIND_NONE, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{8'hF1, 1'b1, '{tnf_pkg::KIND_NONE, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
      // DO GMCP, DO COMPRESS2
      '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_DO, 1'b0, '0},
      '{tnf_pkg::OPT_GMCP, 1'b0, '0},
      '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_DO, 1'b0, '0},
      '{tnf_pkg::OPT_COMP, 1'b0, '0},
      // WILL of an unknown option draws DONT, DO of one draws WONT
      '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_WILL, 1'b0, '0}, '{8'h01, 1'b0, '0},
      '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_DO, 1'b0, '0}, '{8'h00, 1'b0, '0},
      // NAWS 300 x 5: width clamps down to max, height up to min
      '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_SB, 1'b0, '0},
      '{tnf_pkg::OPT_NAWS, 1'b0, '0},
      '{8'h01, 1'b0, '0}, '{8'h2C, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h05, 1'b0, '0}, '{tnf_pkg::B_IAC, 1'b0, '0}, '{tnf_pkg::B_SE, 1'b0, '0}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].event_res);
    drain_events();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: phase_limits = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};   // wide open
        1: phase_limits = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};   // crossed
        2: phase_limits = '{16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(65535)), 16'($urandom_range(65535))};
        3: begin                                                       // pinned
          phase_limits.width_min  = 16'($urandom_range(65535));
          phase_limits.width_max  = phase_limits.width_min;
          phase_limits.height_min = 16'($urandom_range(65535));
          phase_limits.height_max = phase_limits.height_min;
        end
        4: begin                                                       // narrow
          phase_limits.width_min  = 16'($urandom_range(200));
          phase_limits.width_max  = phase_limits.width_min + 16'($urandom_range(300));
          phase_limits.height_min = 16'($urandom_range(60));
          phase_limits.height_max = phase_limits.height_min + 16'($urandom_range(100));
        end
        default: phase_limits = '{tnf_pkg::WIDTH_MIN_RST, tnf_pkg::WIDTH_MAX_RST,
                                  tnf_pkg::HEIGHT_MIN_RST, tnf_pkg::HEIGHT_MAX_RST};
      endcase
      write_limit(tnf_pkg::REG_WIDTH_MIN,  phase_limits.width_min);
      write_limit(tnf_pkg::REG_WIDTH_MAX,  phase_limits.width_max);
      write_limit(tnf_pkg::REG_HEIGHT_MIN, phase_limits.height_min);
      write_limit(tnf_pkg::REG_HEIGHT_MAX, phase_limits.height_max);

      set_idling(phase % 3);
      bytes_sent = 0;
      while (bytes_sent < BYTES_PER_PHASE) send_random_exchange();
      drain_events();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
